// ===== rtl/hvd_pkg.sv =====
// shared types, constants and the arctangent table for the haversine pipeline
package hvd_pkg;

    typedef logic signed [33:0] t_trig;
    typedef logic [30:0] t_dist;

    localparam logic [25:0] RECIP_45     = 26'd47721859;  // ceil(2^31 / 45)
    localparam logic [5:0]  DIV_45       = 6'd45;
    localparam logic [38:0] ROUND_HALF   = 39'd22;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [32:0] KM_4PI_Q16   = 33'd5246834913;
    localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_entry(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hvd_if.sv =====
// valid/ready channel interfaces for point pairs and distances
interface hvd_in_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] first_latitude;
    logic signed [30:0] first_longitude;
    logic signed [29:0] second_latitude;
    logic signed [30:0] second_longitude;

    modport source (output valid, first_latitude, first_longitude,
                    second_latitude, second_longitude, input ready);
    modport sink   (input valid, first_latitude, first_longitude,
                    second_latitude, second_longitude, output ready);
endinterface

interface hvd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_km;

    modport source (output valid, distance_km, input ready);
    modport sink   (input valid, distance_km, output ready);
endinterface

// ===== rtl/hvd_sincos.sv =====
// pipelined rotation cordic giving sine and cosine of a binary angle
module hvd_sincos import hvd_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_ang,
    output t_trig       o_cos,
    output t_trig       o_sin
);

    t_trig      r_x [0:STAGES];
    t_trig      r_y [0:STAGES];
    t_trig      r_z [0:STAGES];
    logic [1:0] r_q [0:STAGES];
    t_trig      r_cos, r_sin;

    logic [31:0] quad_sum, resid;
    assign quad_sum = i_ang + QUARTER_HALF;
    assign resid    = i_ang - {quad_sum[31:30], 30'b0};

    // fold to nearest quadrant, residual within +-45 deg
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= t_trig'({2'b00, CORDIC_GAIN});
            r_y[0] <= '0;
            r_z[0] <= t_trig'(signed'(resid));
            r_q[0] <= quad_sum[31:30];
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        localparam t_trig ATAN = t_trig'({2'b00, atan_entry(i)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STAGES])
                2'd0: begin
                    r_cos <= r_x[STAGES];
                    r_sin <= r_y[STAGES];
                end
                2'd1: begin
                    r_cos <= -r_y[STAGES];
                    r_sin <= r_x[STAGES];
                end
                2'd2: begin
                    r_cos <= -r_x[STAGES];
                    r_sin <= -r_y[STAGES];
                end
                default: begin
                    r_cos <= r_y[STAGES];
                    r_sin <= -r_x[STAGES];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== rtl/hvd_atan2.sv =====
// pipelined vectoring cordic giving atan2(y, x) clamped to a quarter turn
module hvd_atan2 import hvd_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_y,
    input  logic [30:0] i_x,
    output logic [30:0] o_ang
);

    t_trig       r_x [0:STAGES];
    t_trig       r_y [0:STAGES];
    t_trig       r_z [0:STAGES];
    logic [30:0] r_ang;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= t_trig'({3'b000, i_x});
            r_y[0] <= t_trig'({3'b000, i_y});
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        localparam t_trig ATAN = t_trig'({2'b00, atan_entry(i)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][33] && (r_y[i] != '0)) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end
            end
        end
    end

    // clamp to [0, quarter turn]
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z[STAGES][33]) begin
                r_ang <= '0;
            end else if (r_z[STAGES] > t_trig'({3'b000, ONE_Q30})) begin
                r_ang <= ONE_Q30;
            end else begin
                r_ang <= r_z[STAGES][30:0];
            end
        end
    end

    assign o_ang = r_ang;

endmodule

// ===== rtl/haversine_distance.sv =====
// throughput: one pair per cycle unless the output stalls; the whole pipeline advances on one enable
// the pipeline holds only when the output register is full and not taken
// reset: synchronous active low, clears the valid shift register only; no other state
module haversine_distance import hvd_pkg::*; #(
    parameter int TRIG_STAGES = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hvd_in_if.sink           i_in,
    hvd_out_if.source        o_out
);

    // stage budget: 3 degree-to-angle, cordic with load and output stages,
    // 2 products, root load and 31 root steps, vectoring cordic with load
    // and clamp stages, 2 distance multiply stages
    localparam int LATENCY = 2 * TRIG_STAGES + 43;

    logic en;
    logic [LATENCY-1:0] r_vld;

    // advance whenever the output slot is free or being drained
    assign en          = !r_vld[LATENCY-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in.valid};
        end
    end

    // ---------------- degrees to binary angle ----------------
    // full angles scale by 128/45, half differences by 64/45, rounding
    // half away from zero; division by 45 is split in a high and low part
    logic signed [30:0] dlat;
    logic signed [31:0] dlon;
    logic signed [38:0] scaled [4];

    assign dlat = {i_in.second_latitude[29], i_in.second_latitude}
                - {i_in.first_latitude[29], i_in.first_latitude};
    assign dlon = {i_in.second_longitude[30], i_in.second_longitude}
                - {i_in.first_longitude[30], i_in.first_longitude};

    assign scaled[0] = {{2{i_in.first_latitude[29]}}, i_in.first_latitude, 7'b0};
    assign scaled[1] = {{2{i_in.second_latitude[29]}}, i_in.second_latitude, 7'b0};
    assign scaled[2] = {{2{dlat[30]}}, dlat, 6'b0};
    assign scaled[3] = {dlon[31], dlon, 6'b0};

    logic [38:0] r_num [4];
    logic        r_neg1 [4];
    logic [14:0] r_qh2 [4];
    logic [19:0] r_hi2 [4];
    logic [18:0] r_lo2 [4];
    logic        r_neg2 [4];
    logic [14:0] r_qh3 [4];
    logic [18:0] r_ql3 [4];
    logic        r_neg3 [4];
    logic [31:0] ang [4];
    t_trig       cos_v [4];
    t_trig       sin_v [4];

    for (genvar k = 0; k < 4; k++) begin : g_ang
        logic [38:0] mag;
        logic [45:0] prod_h;
        logic [19:0] rem_w;
        logic [24:0] low_num;
        logic [50:0] prod_l;
        logic [33:0] quo;

        assign mag     = scaled[k][38] ? 39'(-scaled[k]) : 39'(scaled[k]);
        assign prod_h  = r_num[k][38:19] * RECIP_45;
        assign rem_w   = r_hi2[k] - 20'(r_qh2[k] * DIV_45);
        assign low_num = {rem_w[5:0], r_lo2[k]};
        assign prod_l  = low_num * RECIP_45;
        assign quo     = {r_qh3[k], 19'b0} + {15'b0, r_ql3[k]};
        assign ang[k]  = r_neg3[k] ? 32'(-quo[31:0]) : quo[31:0];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_num[k]  <= mag + ROUND_HALF;
                r_neg1[k] <= scaled[k][38];
                r_qh2[k]  <= prod_h[45:31];
                r_hi2[k]  <= r_num[k][38:19];
                r_lo2[k]  <= r_num[k][18:0];
                r_neg2[k] <= r_neg1[k];
                r_qh3[k]  <= r_qh2[k];
                r_ql3[k]  <= prod_l[49:31];
                r_neg3[k] <= r_neg2[k];
            end
        end

        hvd_sincos #(.STAGES(TRIG_STAGES)) u_sincos (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ang (ang[k]),
            .o_cos (cos_v[k]),
            .o_sin (sin_v[k])
        );
    end

    // ---------------- haversine term ----------------
    // cos(phi1)cos(phi2), sin^2(dphi/2), sin^2(dlambda/2), all Q30 floor
    logic signed [67:0] p_cc, p_s1, p_s2, p_t;
    t_trig r_cc, r_s1, r_s2, r_s1b, r_t;
    logic signed [34:0] a_sum;

    assign p_cc  = cos_v[0] * cos_v[1];
    assign p_s1  = sin_v[2] * sin_v[2];
    assign p_s2  = sin_v[3] * sin_v[3];
    assign p_t   = r_cc * r_s2;
    assign a_sum = {r_s1b[33], r_s1b} + {r_t[33], r_t};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc  <= p_cc[63:30];
            r_s1  <= p_s1[63:30];
            r_s2  <= p_s2[63:30];
            r_t   <= p_t[63:30];
            r_s1b <= r_s1;
        end
    end

    // clamp to [0, 1] and set up both root operands
    logic [30:0] a_clamp;
    always_comb begin
        if (a_sum[34]) begin
            a_clamp = '0;
        end else if (a_sum > 35'(ONE_Q30)) begin
            a_clamp = ONE_Q30;
        end else begin
            a_clamp = a_sum[30:0];
        end
    end

    // ---------------- square roots ----------------
    // bit-pair restoring root, one bit per stage, both roots side by side
    logic [61:0] r_rn [2][0:31];
    logic [61:0] r_rr [2][0:31];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rn[0][0] <= {1'b0, a_clamp, 30'b0};
            r_rn[1][0] <= {1'b0, ONE_Q30 - a_clamp, 30'b0};
            r_rr[0][0] <= '0;
            r_rr[1][0] <= '0;
        end
    end

    for (genvar m = 0; m < 2; m++) begin : g_root
        for (genvar j = 0; j < 31; j++) begin : g_step
            localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
            logic [61:0] trial;
            assign trial = r_rr[m][j] + BIT;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (r_rn[m][j] >= trial) begin
                        r_rn[m][j+1] <= r_rn[m][j] - trial;
                        r_rr[m][j+1] <= (r_rr[m][j] >> 1) + BIT;
                    end else begin
                        r_rn[m][j+1] <= r_rn[m][j];
                        r_rr[m][j+1] <= r_rr[m][j] >> 1;
                    end
                end
            end
        end
    end

    // ---------------- central angle ----------------
    logic [30:0] half_ang;

    hvd_atan2 #(.STAGES(TRIG_STAGES)) u_atan2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_rr[0][31][30:0]),
        .i_x   (r_rr[1][31][30:0]),
        .o_ang (half_ang)
    );

    // ---------------- distance ----------------
    // z * 6371*4*pi (Q16) split in two partial products, rounded >> 32
    logic [46:0] r_plo;
    logic [47:0] r_phi;
    logic [64:0] dsum;
    t_dist       r_dist;

    assign dsum = {1'b0, r_phi, 16'b0} + {18'b0, r_plo} + (65'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plo  <= half_ang * KM_4PI_Q16[15:0];
            r_phi  <= half_ang * KM_4PI_Q16[32:16];
            r_dist <= dsum[62:32];
        end
    end

    assign o_out.distance_km = r_dist;

endmodule

// ===== rtl/hvd_checker.sv =====
// port-level assertions for the haversine pipeline, bound to the top level
module hvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_distance_km
);

    // distance cannot exceed half the circumference
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_distance_km <= 31'd1311768576))
        else $error("distance beyond half circumference");

    // input side is open whenever the output slot is empty
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_distance_km)))
        else $error("stalled transaction changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled output stalls the input
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while pipeline held");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_distance_km (o_out.distance_km)
);
